>>> hdl/albc_pkg.sv
package albc_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int LEVEL_W    = 8;
   localparam int THRESH_W   = 7;
   localparam int SCALE_W    = 12;
   localparam int PROD_W     = SAMPLE_W + LEVEL_W;
   localparam int SUM_W      = 23;
   localparam int COUNT_W    = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int SAMPLES_PER_AVERAGE_DEF = 5;

   localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RST   = 8'd15;
   localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST   = 8'd255;
   localparam logic [THRESH_W-1:0] THRESH_RST      = 7'd30;
   localparam logic [SCALE_W-1:0]  FULL_SCALE_RST  = 12'd2900;
   localparam logic                FADE_ENABLE_RST = 1'b1;
   localparam logic [LEVEL_W-1:0]  LEVEL_RST       = 8'd150;

   typedef enum logic [2:0] {
      REG_MIN_LEVEL   = 3'd0,
      REG_MAX_LEVEL   = 3'd1,
      REG_THRESHOLD   = 3'd2,
      REG_FULL_SCALE  = 3'd3,
      REG_FADE_ENABLE = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCALE_GO,
      ST_SCALE_WAIT,
      ST_ACC,
      ST_AVG,
      ST_CLAMP,
      ST_ACT
   } state_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> hdl/albc_div.sv
// Restoring divider, one quotient bit per cycle.
module albc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [albc_pkg::SUM_W-1:0]         dividend,
   input  logic [albc_pkg::SCALE_W-1:0]       divisor,
   output albc_pkg::div_stat_type             stat,
   output logic [albc_pkg::SUM_W-1:0]         quotient
);

   localparam int STEP_W = $clog2(albc_pkg::SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(albc_pkg::SUM_W - 1);

   logic                               busy_ff, busy_in;
   logic [STEP_W-1:0]                  step_ff, step_in;
   logic [albc_pkg::SCALE_W-1:0]       rem_ff, rem_in;
   logic [albc_pkg::SUM_W-1:0]         quo_ff;
   logic [albc_pkg::SCALE_W:0]         trial;
   logic [albc_pkg::SCALE_W:0]         trial_sub;
   logic                               fits;

   assign trial     = {rem_ff, quo_ff[albc_pkg::SUM_W-1]};
   assign fits      = trial >= {1'b0, divisor};
   assign trial_sub = trial - {1'b0, divisor};
   assign rem_in    = fits ? trial_sub[albc_pkg::SCALE_W-1:0]
                           : trial[albc_pkg::SCALE_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[albc_pkg::SUM_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (step_ff == LAST_STEP);
   assign quotient  = quo_ff;

endmodule

>>> hdl/ambient_light_backlight_controller_top.sv
// Ambient light backlight controller. Each light request (12-bit reading in
// req_tdata) is scaled to floor(sample * max_level / sensor_full_scale), or to
// max_level when the full scale is zero, and summed. Every SAMPLES_PER_AVERAGE
// requests the sum is divided by SAMPLES_PER_AVERAGE, clamped to
// [min_level, max_level] (max wins if the limits cross) and compared with the
// current level: a difference of 0 or 1 moves the level silently, up to
// jump_threshold steps it by one and emits a result, above that jumps to the
// target and emits with tuser = fade_enable (fade from ramp_from to level).
// A serial divider does the scaling division and the average comes from a
// reciprocal multiply; req_tready is low while a request is in work. A
// finished result sits in an output register, so the next request is taken
// while it waits; the block stalls only if an averaging request finishes
// before the waiting result is taken.
// Registers on the APB port (byte address = 4 * index): 0 min_level,
// 1 max_level, 2 jump_threshold, 3 sensor_full_scale, 4 fade_enable.
// Write them only while the block is idle.
module ambient_light_backlight_controller_top #(
   parameter int SAMPLES_PER_AVERAGE = albc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [11:0] light_sample
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [7:0] level, [15:8] ramp_from
   output logic                                rsp_tuser,   // [0] ramp
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [albc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [albc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [albc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int LW = albc_pkg::LEVEL_W;
   localparam int SW = albc_pkg::SUM_W;
   localparam logic [albc_pkg::COUNT_W:0]   AVG_COUNT   =
      (albc_pkg::COUNT_W+1)'(SAMPLES_PER_AVERAGE);
   // floor(sum / N) = (sum * ceil(2^SHIFT / N)) >> SHIFT, exact for N <= 8
   localparam int AVG_SHIFT = SW + 3;
   localparam int RECIP_W   = AVG_SHIFT + 1;
   localparam int AVG_PW    = SW + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((1 << AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

   // ---------------- configuration registers ----------------
   logic [LW-1:0]                   min_level_ff;
   logic [LW-1:0]                   max_level_ff;
   logic [albc_pkg::THRESH_W-1:0]   thresh_ff;
   logic [albc_pkg::SCALE_W-1:0]    full_scale_ff;
   logic                            fade_ff;
   logic                            csr_write;
   albc_pkg::reg_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = albc_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff  <= albc_pkg::MIN_LEVEL_RST;
         max_level_ff  <= albc_pkg::MAX_LEVEL_RST;
         thresh_ff     <= albc_pkg::THRESH_RST;
         full_scale_ff <= albc_pkg::FULL_SCALE_RST;
         fade_ff       <= albc_pkg::FADE_ENABLE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            albc_pkg::REG_MIN_LEVEL:   min_level_ff  <= csr_pwdata[LW-1:0];
            albc_pkg::REG_MAX_LEVEL:   max_level_ff  <= csr_pwdata[LW-1:0];
            albc_pkg::REG_THRESHOLD:   thresh_ff     <= csr_pwdata[albc_pkg::THRESH_W-1:0];
            albc_pkg::REG_FULL_SCALE:  full_scale_ff <= csr_pwdata[albc_pkg::SCALE_W-1:0];
            albc_pkg::REG_FADE_ENABLE: fade_ff       <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         albc_pkg::REG_MIN_LEVEL:   csr_prdata[LW-1:0] = min_level_ff;
         albc_pkg::REG_MAX_LEVEL:   csr_prdata[LW-1:0] = max_level_ff;
         albc_pkg::REG_THRESHOLD:   csr_prdata[albc_pkg::THRESH_W-1:0] = thresh_ff;
         albc_pkg::REG_FULL_SCALE:  csr_prdata[albc_pkg::SCALE_W-1:0] = full_scale_ff;
         albc_pkg::REG_FADE_ENABLE: csr_prdata[0] = fade_ff;
         default: ;
      endcase
   end

   // ---------------- datapath state ----------------
   albc_pkg::state_type             state_ff, state_in;
   logic [albc_pkg::SAMPLE_W-1:0]   raw_ff;
   logic [albc_pkg::PROD_W-1:0]     prod_ff;
   logic [SW-1:0]                   sum_ff, sum_in;
   logic [albc_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [SW-1:0]                   avg_ff;
   logic [AVG_PW-1:0]               avg_prod;
   logic [LW-1:0]                   target_ff, target_in;
   logic [LW-1:0]                   level_ff;
   logic                            rsp_valid_ff;
   logic [LW-1:0]                   rsp_level_ff;
   logic [LW-1:0]                   rsp_from_ff;
   logic                            rsp_ramp_ff;

   // sequencer controls
   logic                            div_start;
   logic                            acc_en;
   logic                            clamp_en;
   logic                            act_en;
   logic                            out_free;
   logic                            last_sample;

   // scaling divider
   albc_pkg::div_stat_type          div_stat;
   logic [SW-1:0]                   div_dividend;
   logic [albc_pkg::SCALE_W-1:0]    div_divisor;
   logic [SW-1:0]                   div_quotient;

   // scaling division: product over full scale
   assign div_dividend = SW'(prod_ff);
   assign div_divisor  = full_scale_ff;

   albc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign last_sample = ({1'b0, count_ff} + 1'b1) >= AVG_COUNT;
   assign avg_prod    = AVG_PW'(sum_ff) * AVG_PW'(AVG_RECIP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         albc_pkg::ST_IDLE:       if (req_tvalid)    state_in = albc_pkg::ST_MUL;
         albc_pkg::ST_MUL:                           state_in = albc_pkg::ST_SCALE_GO;
         albc_pkg::ST_SCALE_GO:                      state_in = albc_pkg::ST_SCALE_WAIT;
         albc_pkg::ST_SCALE_WAIT: if (div_stat.done) state_in = albc_pkg::ST_ACC;
         albc_pkg::ST_ACC: begin
            state_in = last_sample ? albc_pkg::ST_AVG : albc_pkg::ST_IDLE;
         end
         albc_pkg::ST_AVG:                           state_in = albc_pkg::ST_CLAMP;
         albc_pkg::ST_CLAMP:                         state_in = albc_pkg::ST_ACT;
         albc_pkg::ST_ACT:        if (out_free)      state_in = albc_pkg::ST_IDLE;
         default:                                    state_in = albc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      acc_en     = 1'b0;
      clamp_en   = 1'b0;
      act_en     = 1'b0;
      unique case (state_ff)
         albc_pkg::ST_IDLE:     req_tready = 1'b1;
         albc_pkg::ST_SCALE_GO: div_start  = 1'b1;
         albc_pkg::ST_ACC:      acc_en     = 1'b1;
         albc_pkg::ST_CLAMP:    clamp_en   = 1'b1;
         albc_pkg::ST_ACT:      act_en     = out_free;
         default: ;
      endcase
   end

   // accumulate; a zero full scale saturates the scaled sample to max_level
   always_comb begin
      logic [SW-1:0] scaled;
      scaled   = (full_scale_ff == '0) ? SW'(max_level_ff) : div_quotient;
      sum_in   = sum_ff + scaled;
      count_in = last_sample ? '0 : count_ff + 1'b1;
   end

   // clamp: min first, then max wins
   always_comb begin
      logic [SW-1:0] lo;
      lo = (avg_ff < SW'(min_level_ff)) ? SW'(min_level_ff) : avg_ff;
      target_in = (lo > SW'(max_level_ff)) ? max_level_ff : lo[LW-1:0];
   end

   // decision against the current level
   logic [LW-1:0] diff;
   logic          step_move;
   logic          jump_move;
   logic [LW-1:0] next_level;

   always_comb begin
      diff       = (level_ff > target_ff) ? level_ff - target_ff : target_ff - level_ff;
      jump_move  = diff > {1'b0, thresh_ff};
      step_move  = (diff > 8'd1) && !jump_move;
      next_level = target_ff;
      if (step_move) begin
         next_level = (level_ff < target_ff) ? level_ff + 1'b1 : level_ff - 1'b1;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= albc_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         level_ff     <= albc_pkg::LEVEL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_en) begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end else if (act_en) begin
            sum_ff   <= '0;
         end
         if (act_en) begin
            level_ff <= next_level;
         end
         if (act_en && (step_move || jump_move)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         raw_ff <= req_tdata[albc_pkg::SAMPLE_W-1:0];
      end
      if (state_ff == albc_pkg::ST_MUL) begin
         prod_ff <= albc_pkg::PROD_W'(raw_ff) * albc_pkg::PROD_W'(max_level_ff);
      end
      if (state_ff == albc_pkg::ST_AVG) begin
         avg_ff <= avg_prod[AVG_SHIFT +: SW];
      end
      if (clamp_en) begin
         target_ff <= target_in;
      end
      if (act_en && (step_move || jump_move)) begin
         rsp_level_ff <= next_level;
         rsp_from_ff  <= level_ff;
         rsp_ramp_ff  <= jump_move & fade_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_from_ff, rsp_level_ff};
   assign rsp_tuser  = rsp_ramp_ff;

endmodule

>>> hdl/albc_check.sv
module albc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // a result is only sent when the level changes
   a_level_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] != rsp_tdata[15:8])
      else $error("result without level change");

   // after reset: idle and nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind ambient_light_backlight_controller_top albc_check u_albc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
